@@ src/vrc_pkg.sv @@
// ----------------------------------------------------------------------------
// vrc_pkg
// Types, constants and the color lookup shared by the value-to-RGB colormap.
// ----------------------------------------------------------------------------
`default_nettype none

package vrc_pkg;

    localparam int CfgBits   = 32;
    localparam int IndexBits = 2;
    localparam int KBits     = 10;
    localparam int LevelBits = 11;
    localparam int ColorBits = 8;

    localparam int DefaultValueBits = 32;

    localparam logic [CfgBits-1:0] RangeLowReset  = 32'd0;
    localparam logic [CfgBits-1:0] RangeHighReset = 32'd65536;

    localparam logic [KBits-1:0] KGray = 10'd255;
    localparam logic [KBits-1:0] KHot  = 10'(3 * 255);
    localparam logic [KBits-1:0] KJet  = 10'(4 * 256 - 1);

    localparam logic [LevelBits-1:0] LvHotTop    = 11'(3 * 255);
    localparam logic [LevelBits-1:0] LvHotMid    = 11'(2 * 255);
    localparam logic [LevelBits-1:0] LvHotLow    = 11'd255;
    localparam logic [LevelBits-1:0] LvJetTop    = 11'(4 * 256 - 1);
    localparam logic [LevelBits-1:0] LvJetSeg4   = 11'(3 * 256 + 127);
    localparam logic [LevelBits-1:0] LvJetSeg3   = 11'(2 * 256 + 127);
    localparam logic [LevelBits-1:0] LvJetSeg2   = 11'(256 + 127);
    localparam logic [LevelBits-1:0] LvJetSeg1   = 11'd127;
    localparam logic [LevelBits-1:0] LvJetBase   = 11'd128;
    localparam logic [LevelBits-1:0] LvJetFall   = 11'(4 * 256 + 127);
    localparam logic [LevelBits-1:0] LvJetMidEnd = 11'(2 * 256 + 127);
    localparam logic [LevelBits-1:0] LvJetSeg3Lo = 11'(256 + 128);
    localparam logic [LevelBits-1:0] LvGrayMax   = 11'd255;

    localparam logic [ColorBits-1:0] ColorFull = 8'd255;

    typedef enum logic [IndexBits-1:0] {
        REG_MAP_SELECT = 2'd0,
        REG_RANGE_LOW  = 2'd1,
        REG_RANGE_HIGH = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        MAP_GRAY = 2'd0,
        MAP_HOT  = 2'd1,
        MAP_JET  = 2'd2
    } map_t;

    typedef struct packed {
        map_t map;
        logic force_white;
        logic over_top;
    } side_t;

    typedef struct packed {
        logic [ColorBits-1:0] blue;
        logic [ColorBits-1:0] green;
        logic [ColorBits-1:0] red;
    } rgb_t;

    function automatic logic [KBits-1:0] map_scale(input map_t map);
        logic [KBits-1:0] k;
        case (map)
            MAP_GRAY: k = KGray;
            MAP_HOT:  k = KHot;
            MAP_JET:  k = KJet;
            default:  k = KGray;
        endcase
        return k;
    endfunction

    function automatic rgb_t color_lookup(input side_t side, input logic [LevelBits-1:0] quo);
        rgb_t                 px;
        logic [LevelBits-1:0] lv;
        logic [LevelBits-1:0] t;
        px = '0;
        lv = side.over_top ? (LevelBits'(map_scale(side.map)) + 11'd1) : quo;
        t  = '0;
        if (side.force_white) begin
            px = '{ColorFull, ColorFull, ColorFull};
        end else begin
            case (side.map)
                MAP_GRAY:
                begin
                    t = (lv > LvGrayMax) ? LvGrayMax : lv;
                    px.red   = t[ColorBits-1:0];
                    px.green = t[ColorBits-1:0];
                    px.blue  = t[ColorBits-1:0];
                end
                MAP_HOT:
                begin
                    if (lv > LvHotTop) begin
                        px = '{ColorFull, ColorFull, ColorFull};
                    end else if (lv > LvHotMid) begin
                        t = lv - LvHotMid;
                        px = '{t[ColorBits-1:0], ColorFull, ColorFull};
                    end else if (lv > LvHotLow) begin
                        t = lv - LvHotLow;
                        px = '{8'd0, t[ColorBits-1:0], ColorFull};
                    end else begin
                        px = '{8'd0, 8'd0, lv[ColorBits-1:0]};
                    end
                end
                MAP_JET:
                begin
                    if (lv > LvJetTop) begin
                        px = '{ColorFull, ColorFull, ColorFull};
                    end else if (lv > LvJetSeg4) begin
                        t = LvJetFall - lv;
                        px = '{8'd0, 8'd0, t[ColorBits-1:0]};
                    end else if (lv > LvJetSeg3) begin
                        t = LvJetSeg4 - lv;
                        px = '{8'd0, t[ColorBits-1:0], ColorFull};
                    end else if (lv > LvJetSeg2) begin
                        px.red   = 8'(lv - LvJetSeg3Lo);
                        px.green = ColorFull;
                        px.blue  = 8'(LvJetMidEnd - lv);
                    end else if (lv > LvJetSeg1) begin
                        t = lv - LvJetBase;
                        px = '{ColorFull, t[ColorBits-1:0], 8'd0};
                    end else begin
                        t = LvJetBase + lv;
                        px = '{t[ColorBits-1:0], 8'd0, 8'd0};
                    end
                end
                default:
                begin
                    px = '0;
                end
            endcase
        end
        return px;
    endfunction

endpackage

`default_nettype wire

@@ src/value_to_rgb_colormap.sv @@
// ----------------------------------------------------------------------------
// value_to_rgb_colormap
// Scales a fixed-point sample against a configured range and maps the level
// to an RGB pixel through a grayscale, hot or jet colormap.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         tdata: sample_value
//  m_axis    out        tdata: red_level, green_level, blue_level
//  cfg       in         we, index, data: map_select, range_low, range_high
//
//  One sample is accepted every clock while the output does not stall.
//  The pipeline is the subtract and multiply stages, the 11-stage divider
//  that forms the level and the output register.
//  Reset clears the pipeline valid bits and restores the register defaults.
//  A stall on the output freezes the whole pipeline and s_tready falls.
// ----------------------------------------------------------------------------
`default_nettype none

module value_to_rgb_colormap #(
    parameter int VALUE_BITS = vrc_pkg::DefaultValueBits
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // sample_value
    input  wire logic [8*((VALUE_BITS+7)/8)-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // red_level, green_level, blue_level
    output logic [3*vrc_pkg::ColorBits-1:0]        m_tdata,
    input  wire logic                              cfg_we,
    input  wire logic [vrc_pkg::IndexBits-1:0]     cfg_index,
    input  wire logic [vrc_pkg::CfgBits-1:0]       cfg_data
);

    import vrc_pkg::*;

    localparam int ProdBits = VALUE_BITS + KBits;

    map_t                map_select_reg;
    logic [CfgBits-1:0]  range_low_reg;
    logic [CfgBits-1:0]  range_high_reg;

    logic                  en;
    logic [VALUE_BITS-1:0] sample;
    logic [VALUE_BITS-1:0] lo_val;
    logic [VALUE_BITS-1:0] hi_val;
    logic [VALUE_BITS:0]   diff_next;

    logic                  a_valid_reg;
    logic [VALUE_BITS-1:0] a_diff_reg;
    logic                  a_borrow_reg;
    logic [VALUE_BITS-1:0] a_span_reg;
    side_t                 a_side_reg;

    logic [VALUE_BITS-1:0] b_a;
    side_t                 b_side_next;
    logic [ProdBits-1:0]   b_prod_next;
    logic                  b_valid_reg;
    logic [ProdBits-1:0]   b_prod_reg;
    logic [VALUE_BITS-1:0] b_span_reg;
    side_t                 b_side_reg;

    logic                  d_valid;
    logic [LevelBits-1:0]  d_quo;
    side_t                 d_side;

    logic                  out_valid_reg;
    rgb_t                  out_rgb_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            map_select_reg <= MAP_GRAY;
            range_low_reg  <= RangeLowReset;
            range_high_reg <= RangeHighReset;
        end else if (cfg_we) begin
            case (reg_index_t'(cfg_index))
                REG_MAP_SELECT: map_select_reg <= map_t'(cfg_data[1:0]);
                REG_RANGE_LOW:  range_low_reg  <= cfg_data;
                REG_RANGE_HIGH: range_high_reg <= cfg_data;
                default:        ;
            endcase
        end
    end

    assign en       = !out_valid_reg || m_tready;
    assign s_tready = en;

    assign sample    = s_tdata[VALUE_BITS-1:0];
    assign lo_val    = VALUE_BITS'(range_low_reg);
    assign hi_val    = VALUE_BITS'(range_high_reg);
    assign diff_next = {1'b0, sample} - {1'b0, lo_val};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (en) begin
            a_valid_reg   <= s_tvalid;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= d_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            a_diff_reg             <= diff_next[VALUE_BITS-1:0];
            a_borrow_reg           <= diff_next[VALUE_BITS];
            a_span_reg             <= hi_val - lo_val;
            a_side_reg.map         <= map_select_reg;
            a_side_reg.force_white <= (hi_val <= lo_val);
            a_side_reg.over_top    <= 1'b0;
        end
    end

    always_comb
    begin
        b_a                  = a_borrow_reg ? '0 : a_diff_reg;
        b_side_next          = a_side_reg;
        b_side_next.over_top = ({1'b0, b_a} >= {a_span_reg, 1'b0});
        b_prod_next          = ProdBits'(b_a) * ProdBits'(map_scale(a_side_reg.map));
    end

    always_ff @(posedge clk)
    begin
        if (en) begin
            b_prod_reg <= b_prod_next;
            b_span_reg <= a_span_reg;
            b_side_reg <= b_side_next;
        end
    end

    vrc_div_pipe #(
        .VALUE_BITS (VALUE_BITS)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (b_valid_reg),
        .in_num    (b_prod_reg),
        .in_span   (b_span_reg),
        .in_side   (b_side_reg),
        .out_valid (d_valid),
        .out_quo   (d_quo),
        .out_side  (d_side)
    );

    always_ff @(posedge clk)
    begin
        if (en) begin
            out_rgb_reg <= color_lookup(d_side, d_quo);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_rgb_reg;

endmodule

`default_nettype wire

@@ src/vrc_div_pipe.sv @@
// ----------------------------------------------------------------------------
// vrc_div_pipe
// Pipelined restoring divider, one quotient bit per stage, with sideband.
// ----------------------------------------------------------------------------
`default_nettype none

module vrc_div_pipe #(
    parameter int VALUE_BITS = vrc_pkg::DefaultValueBits
) (
    input  wire logic                                   clk,
    input  wire logic                                   rst_n,
    input  wire logic                                   en,
    input  wire logic                                   in_valid,
    input  wire logic [VALUE_BITS+vrc_pkg::KBits-1:0]   in_num,
    input  wire logic [VALUE_BITS-1:0]                  in_span,
    input  wire vrc_pkg::side_t                         in_side,
    output logic                                        out_valid,
    output logic [vrc_pkg::LevelBits-1:0]               out_quo,
    output vrc_pkg::side_t                              out_side
);

    import vrc_pkg::*;

    localparam int ProdBits = VALUE_BITS + KBits;

    logic                 valid_reg [LevelBits];
    logic [ProdBits-1:0]  rem_reg   [LevelBits];
    logic [LevelBits-1:0] quo_reg   [LevelBits];
    logic [VALUE_BITS-1:0] span_reg [LevelBits];
    side_t                side_reg  [LevelBits];

    for (genvar s = 0; s < LevelBits; s++) begin : g_stage
        localparam int Shift = LevelBits - 1 - s;

        logic                  valid_prev;
        logic [ProdBits-1:0]   rem_prev;
        logic [LevelBits-1:0]  quo_prev;
        logic [VALUE_BITS-1:0] span_prev;
        side_t                 side_prev;
        logic [ProdBits-1:0]   divisor;
        logic                  fits;
        logic [ProdBits-1:0]   rem_next;
        logic [LevelBits-1:0]  quo_next;

        if (s == 0) begin : g_first
            assign valid_prev = in_valid;
            assign rem_prev   = in_num;
            assign quo_prev   = '0;
            assign span_prev  = in_span;
            assign side_prev  = in_side;
        end else begin : g_rest
            assign valid_prev = valid_reg[s-1];
            assign rem_prev   = rem_reg[s-1];
            assign quo_prev   = quo_reg[s-1];
            assign span_prev  = span_reg[s-1];
            assign side_prev  = side_reg[s-1];
        end

        always_comb
        begin
            divisor  = ProdBits'(span_prev) << Shift;
            fits     = (rem_prev >= divisor);
            rem_next = fits ? (rem_prev - divisor) : rem_prev;
            quo_next = {quo_prev[LevelBits-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n) begin
                valid_reg[s] <= 1'b0;
            end else if (en) begin
                valid_reg[s] <= valid_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en) begin
                rem_reg[s]  <= rem_next;
                quo_reg[s]  <= quo_next;
                span_reg[s] <= span_prev;
                side_reg[s] <= side_prev;
            end
        end
    end

    assign out_valid = valid_reg[LevelBits-1];
    assign out_quo   = quo_reg[LevelBits-1];
    assign out_side  = side_reg[LevelBits-1];

endmodule

`default_nettype wire
